FILE: sv/sprite_frame_rect_generator_top_assert.svh
// Assertion macros for the sprite frame rectangle generator.
`ifndef SPRITE_FRAME_RECT_GENERATOR_TOP_ASSERT_SVH
`define SPRITE_FRAME_RECT_GENERATOR_TOP_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define SFRG_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define SFRG_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/sfrg_pkg.sv
// Shared widths, limits and register codes of the sprite frame rectangle generator.
`default_nettype none

package sfrg_pkg;

  localparam int unsigned START_W    = 12;
  localparam int unsigned FRAMES_W   = 13;
  localparam int unsigned FTICKS_W   = 24;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned PER_ROW_W  = 9;
  localparam int unsigned TICKS_W    = 8;
  localparam int unsigned ELAPSED_W  = 25;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned SPRITE_W   = 13;
  localparam int unsigned LEFT_W     = 20;
  localparam int unsigned TOP_W      = 25;
  localparam int unsigned RWIDTH_W   = 13;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned PDATA_W    = 32;

  // Shared divider: 13-bit dividend and divisor, one quotient bit per cycle.
  localparam int unsigned DIV_W      = 13;
  localparam int unsigned DIV_CNT_W  = 4;

  localparam logic [FRAMES_W-1:0]  MAX_FRAMES  = FRAMES_W'(4096);
  localparam logic [PER_ROW_W-1:0] MAX_PER_ROW = PER_ROW_W'(256);
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [2:0] REG_START_INDEX     = 3'd0;
  localparam logic [2:0] REG_FRAME_COUNT     = 3'd1;
  localparam logic [2:0] REG_FRAME_TICKS     = 3'd2;
  localparam logic [2:0] REG_SPRITE_WIDTH    = 3'd3;
  localparam logic [2:0] REG_SPRITE_HEIGHT   = 3'd4;
  localparam logic [2:0] REG_SPRITES_PER_ROW = 3'd5;
  localparam logic [2:0] REG_MIRROR          = 3'd6;
  localparam logic [2:0] REG_UNUSED          = 3'd7;

endpackage

`default_nettype wire

FILE: sv/sprite_frame_rect_generator_top.sv
// A tick transaction is accepted only in the idle state. On a frame advance the shared
// restoring divider first wraps the frame position modulo the frame count; on every
// transaction it splits the sprite index into row and column, then the products are scaled.
// A new transaction is taken while the previous result still waits in the output register.
// Reset (rst, synchronous, active high) restores the register defaults, clears timer,
// frame position and sprite index, and empties the output register.
`default_nettype none
`include "sprite_frame_rect_generator_top_assert.svh"

module sprite_frame_rect_generator_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sfrg_pkg::PADDR_W-1:0]       paddr,
  input  wire logic [sfrg_pkg::PDATA_W-1:0]       pwdata,
  output logic      [sfrg_pkg::PDATA_W-1:0]       prdata,
  output logic                                    pready,
  // tick input channel
  input  wire logic                               ticks_valid,
  output logic                                    ticks_ready,
  input  wire logic [sfrg_pkg::TICKS_W-1:0]       ticks,
  // rectangle output channel
  output logic                                    rect_valid,
  input  wire logic                               rect_ready,
  output logic        [sfrg_pkg::LEFT_W-1:0]      rect_left,
  output logic        [sfrg_pkg::TOP_W-1:0]       rect_top,
  output logic signed [sfrg_pkg::RWIDTH_W-1:0]    rect_width,
  output logic        [sfrg_pkg::SIZE_W-1:0]      rect_height,
  output logic        [sfrg_pkg::SPRITE_W-1:0]    current_sprite
);
  import sfrg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,     // wait for a tick transaction
    S_DIV_POS,  // wrap the next frame position modulo the frame count
    S_DIV_SPR,  // split the sprite index into row and column
    S_MUL,      // scale row and column by the sprite size
    S_DONE      // hand the rectangle to the output register
  } state_t;

  state_t state;

  // Configuration registers
  logic [START_W-1:0]   anim_start;
  logic [FRAMES_W-1:0]  loop_frames;
  logic [FTICKS_W-1:0]  frame_ticks;
  logic [SIZE_W-1:0]    tile_w;
  logic [SIZE_W-1:0]    tile_h;
  logic [PER_ROW_W-1:0] sprites_per_row;
  logic                 mirror;

  // Animation state
  logic [ELAPSED_W-1:0] elapsed_ticks;
  logic [POS_W-1:0]     frame_position;
  logic [SPRITE_W-1:0]  sprite_index;

  // Shared divider: remainder, dividend shifting into quotient, divisor, step count
  logic [DIV_W-1:0]     div_rem;
  logic [DIV_W-1:0]     div_quo;
  logic [DIV_W-1:0]     div_den;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Row/column and scaled products
  logic [COL_W-1:0]     col;
  logic [SPRITE_W-1:0]  row;
  logic [LEFT_W-1:0]    left_prod;
  logic [TOP_W-1:0]     top_prod;

  // Combinational helpers
  logic [DIV_W-1:0]     frames_eff;
  logic [DIV_W-1:0]     per_row_eff;
  logic [ELAPSED_W:0]   elapsed_sum;
  logic [ELAPSED_W-1:0] elapsed_sat;
  logic                 advance;
  logic [DIV_W-1:0]     div_trial;
  logic                 div_ge;
  logic [DIV_W-1:0]     div_rem_next;
  logic [DIV_W-1:0]     div_quo_next;
  logic                 div_last;
  logic [SPRITE_W-1:0]  sprite_next;
  logic [LEFT_W:0]      left_sum;
  logic [RWIDTH_W-1:0]  width_signed;
  logic                 cfg_wr;
  logic [2:0]           cfg_idx;
  logic                 in_take;

  assign pready      = 1'b1;
  assign ticks_ready = (state == S_IDLE);
  assign in_take     = ticks_valid && ticks_ready;
  assign cfg_idx     = paddr[PADDR_W-1:2];
  assign cfg_wr      = psel && penable && pwrite && pready;

  always_comb begin
    // Clamp frame count to 1..4096 and sprites per row to 1..256
    priority if (loop_frames == '0) begin
      frames_eff = DIV_W'(1);
    end else if (loop_frames > MAX_FRAMES) begin
      frames_eff = DIV_W'(MAX_FRAMES);
    end else begin
      frames_eff = DIV_W'(loop_frames);
    end

    priority if (sprites_per_row == '0) begin
      per_row_eff = DIV_W'(1);
    end else if (sprites_per_row > MAX_PER_ROW) begin
      per_row_eff = DIV_W'(MAX_PER_ROW);
    end else begin
      per_row_eff = DIV_W'(sprites_per_row);
    end

    // Saturating timer update and frame advance test
    elapsed_sum = {1'b0, elapsed_ticks} + (ELAPSED_W+1)'(ticks);
    elapsed_sat = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX : elapsed_sum[ELAPSED_W-1:0];
    advance     = elapsed_sat > ELAPSED_W'(frame_ticks);

    // One restoring division step; remainder stays below divisor so no top bit is lost
    div_trial    = {div_rem[DIV_W-2:0], div_quo[DIV_W-1]};
    div_ge       = div_trial >= div_den;
    div_rem_next = div_ge ? (div_trial - div_den) : div_trial;
    div_quo_next = {div_quo[DIV_W-2:0], div_ge};
    div_last     = (div_cnt == '0);

    sprite_next  = SPRITE_W'(anim_start) + SPRITE_W'(div_rem_next[POS_W-1:0]);

    // Mirrored sprites start one width further right and carry a negative width
    left_sum     = {1'b0, left_prod} + (LEFT_W+1)'(mirror ? tile_w : '0);
    width_signed = mirror ? (RWIDTH_W'(0) - RWIDTH_W'(tile_w))
                          : RWIDTH_W'(tile_w);
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      REG_START_INDEX:     prdata = PDATA_W'(anim_start);
      REG_FRAME_COUNT:     prdata = PDATA_W'(loop_frames);
      REG_FRAME_TICKS:     prdata = PDATA_W'(frame_ticks);
      REG_SPRITE_WIDTH:    prdata = PDATA_W'(tile_w);
      REG_SPRITE_HEIGHT:   prdata = PDATA_W'(tile_h);
      REG_SPRITES_PER_ROW: prdata = PDATA_W'(sprites_per_row);
      REG_MIRROR:          prdata = PDATA_W'(mirror);
      REG_UNUSED:          prdata = '0;
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      rect_valid      <= 1'b0;
      anim_start      <= '0;
      loop_frames     <= FRAMES_W'(1);
      frame_ticks     <= '0;
      tile_w          <= SIZE_W'(1);
      tile_h          <= SIZE_W'(1);
      sprites_per_row <= PER_ROW_W'(1);
      mirror          <= 1'b0;
      elapsed_ticks   <= '0;
      frame_position  <= '0;
      sprite_index    <= '0;
      div_cnt         <= '0;
    end else begin
      // Drop the result once the consumer has taken it, unless a new one replaces it
      if (rect_valid && rect_ready && (state != S_DONE)) begin
        rect_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            div_rem <= '0;
            div_cnt <= DIV_CNT_W'(DIV_W - 1);
            if (advance) begin
              // Wrap position + 1 modulo the frame count; ticks of this transaction are lost
              elapsed_ticks <= '0;
              div_quo       <= DIV_W'(frame_position) + DIV_W'(1);
              div_den       <= frames_eff;
              state         <= S_DIV_POS;
            end else begin
              elapsed_ticks <= elapsed_sat;
              div_quo       <= DIV_W'(sprite_index);
              div_den       <= per_row_eff;
              state         <= S_DIV_SPR;
            end
          end
        end

        S_DIV_POS: begin
          if (div_last) begin
            frame_position <= div_rem_next[POS_W-1:0];
            sprite_index   <= sprite_next;
            // Reuse the divider for the row/column split of the new sprite
            div_rem        <= '0;
            div_quo        <= DIV_W'(sprite_next);
            div_den        <= per_row_eff;
            div_cnt        <= DIV_CNT_W'(DIV_W - 1);
            state          <= S_DIV_SPR;
          end else begin
            div_rem <= div_rem_next;
            div_quo <= div_quo_next;
            div_cnt <= div_cnt - DIV_CNT_W'(1);
          end
        end

        S_DIV_SPR: begin
          if (div_last) begin
            col   <= div_rem_next[COL_W-1:0];
            row   <= SPRITE_W'(div_quo_next);
            state <= S_MUL;
          end else begin
            div_rem <= div_rem_next;
            div_quo <= div_quo_next;
            div_cnt <= div_cnt - DIV_CNT_W'(1);
          end
        end

        S_MUL: begin
          left_prod <= LEFT_W'(col) * LEFT_W'(tile_w);
          top_prod  <= TOP_W'(row) * TOP_W'(tile_h);
          state     <= S_DONE;
        end

        S_DONE: begin
          // Hold until the output register is free
          if (!rect_valid || rect_ready) begin
            rect_left      <= left_sum[LEFT_W-1:0];
            rect_top       <= top_prod;
            rect_width     <= width_signed;
            rect_height    <= tile_h;
            current_sprite <= sprite_index;
            rect_valid     <= 1'b1;
            state          <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // Configuration writes must arrive only while the block is idle; the block itself does not enforce this
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_START_INDEX: begin
            anim_start     <= pwdata[START_W-1:0];
            sprite_index   <= SPRITE_W'(pwdata[START_W-1:0]);
            frame_position <= '0;
            elapsed_ticks  <= '0;
          end
          REG_FRAME_COUNT:     loop_frames     <= pwdata[FRAMES_W-1:0];
          REG_FRAME_TICKS:     frame_ticks     <= pwdata[FTICKS_W-1:0];
          REG_SPRITE_WIDTH:    tile_w          <= pwdata[SIZE_W-1:0];
          REG_SPRITE_HEIGHT:   tile_h          <= pwdata[SIZE_W-1:0];
          REG_SPRITES_PER_ROW: sprites_per_row <= pwdata[PER_ROW_W-1:0];
          REG_MIRROR:          mirror          <= pwdata[0];
          REG_UNUSED: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Divider remainder must stay below the divisor while iterating
  `SFRG_ASSERT_SAME(a_div_rem_bound, clk, rst,
    (state == S_DIV_POS || state == S_DIV_SPR), (div_rem < div_den),
    "divider remainder reached divisor")
  // An accepted transaction always starts a division
  `SFRG_ASSERT_NEXT(a_accept_to_div, clk, rst,
    in_take, (state == S_DIV_POS || state == S_DIV_SPR),
    "accepted transaction did not start the divider")
  // A wrapped frame position lies inside the frame count
  `SFRG_ASSERT_SAME(a_pos_in_range, clk, rst,
    (state == S_DIV_SPR && $past(state) == S_DIV_POS),
    (DIV_W'(frame_position) < frames_eff), "frame position outside frame count")
  // A fresh result reports the sprite index it was computed from
  `SFRG_ASSERT_SAME(a_sprite_match, clk, rst,
    $rose(rect_valid), (current_sprite == sprite_index),
    "result sprite differs from state")

endmodule

`default_nettype wire

FILE: verif/sprite_frame_rect_generator_top_test.sv
// Self-checking testbench for the sprite frame rectangle generator: directed table, then random phases.
`timescale 1ns / 1ps

module sprite_frame_rect_generator_top_test;
  import sfrg_pkg::*;

  localparam int unsigned CLK_HALF      = 2;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned RANDOM_ITEMS  = 1750;
  // The worst accept-to-result latency comes on a frame advance; leave margin.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned IDLE_PERCENT  = 6;
  // Window of transactions with no idling on either side.
  localparam int unsigned CALM_FIRST    = 700;
  localparam int unsigned CALM_LAST     = 1000;

  typedef struct packed {
    logic        [LEFT_W-1:0]   left;
    logic        [TOP_W-1:0]    top;
    logic signed [RWIDTH_W-1:0] width;
    logic        [SIZE_W-1:0]   height;
    logic        [SPRITE_W-1:0] sprite;
  } rect_t;

  // One row of the directed table: a register write or a tick transaction.
  typedef struct {
    bit                 is_write;
    logic [2:0]         reg_idx;
    logic [PDATA_W-1:0] data;
    logic [TICKS_W-1:0] tick_count;
    bit                 fixed;
    rect_t              want;
  } step_t;

  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      psel        = 1'b0;
  logic                      penable     = 1'b0;
  logic                      pwrite      = 1'b0;
  logic [PADDR_W-1:0]        paddr       = '0;
  logic [PDATA_W-1:0]        pwdata      = '0;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      ticks_valid = 1'b0;
  logic                      ticks_ready;
  logic [TICKS_W-1:0]        ticks       = '0;
  logic                      rect_valid;
  logic                      rect_ready  = 1'b0;
  logic        [LEFT_W-1:0]   rect_left;
  logic        [TOP_W-1:0]    rect_top;
  logic signed [RWIDTH_W-1:0] rect_width;
  logic        [SIZE_W-1:0]   rect_height;
  logic        [SPRITE_W-1:0] current_sprite;

  // Shadow copy of the configuration registers, at their reset values.
  logic [START_W-1:0]   cfg_start   = '0;
  logic [FRAMES_W-1:0]  cfg_frames  = FRAMES_W'(1);
  logic [FTICKS_W-1:0]  cfg_fticks  = '0;
  logic [SIZE_W-1:0]    cfg_width   = SIZE_W'(1);
  logic [SIZE_W-1:0]    cfg_height  = SIZE_W'(1);
  logic [PER_ROW_W-1:0] cfg_per_row = PER_ROW_W'(1);
  logic                 cfg_mirror  = 1'b0;

  // Shadow animation state.
  logic [ELAPSED_W-1:0] anim_elapsed  = '0;
  logic [POS_W-1:0]     anim_position = '0;
  logic [SPRITE_W-1:0]  anim_sprite   = '0;

  rect_t       rects_due[$];
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned ticks_sent   = 0;
  bit          calm         = 1'b0;
  bit          unsettled    = 1'b0;

  sprite_frame_rect_generator_top dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .ticks_valid    (ticks_valid),
    .ticks_ready    (ticks_ready),
    .ticks          (ticks),
    .rect_valid     (rect_valid),
    .rect_ready     (rect_ready),
    .rect_left      (rect_left),
    .rect_top       (rect_top),
    .rect_width     (rect_width),
    .rect_height    (rect_height),
    .current_sprite (current_sprite)
  );

  always #(CLK_HALF) clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Receiver: stall now and then, except inside the calm window.
  always @(negedge clk) begin
    rect_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
  end

  function automatic logic [PADDR_W-1:0] reg_addr(logic [2:0] idx);
    return PADDR_W'({idx, 2'b00});
  endfunction

  function automatic rect_t rect_of(int unsigned l, int unsigned t, int w, int unsigned h,
                                    int unsigned s);
    rect_t r;
    r.left   = LEFT_W'(l);
    r.top    = TOP_W'(t);
    r.width  = RWIDTH_W'(w);
    r.height = SIZE_W'(h);
    r.sprite = SPRITE_W'(s);
    return r;
  endfunction

  function automatic step_t write_row(logic [2:0] idx, logic [PDATA_W-1:0] data);
    step_t s;
    s = '{default: '0};
    s.is_write = 1'b1;
    s.reg_idx  = idx;
    s.data     = data;
    return s;
  endfunction

  function automatic step_t tick_row(logic [TICKS_W-1:0] t);
    step_t s;
    s = '{default: '0};
    s.tick_count = t;
    return s;
  endfunction

  function automatic step_t fixed_row(logic [TICKS_W-1:0] t, rect_t want);
    step_t s;
    s = tick_row(t);
    s.fixed = 1'b1;
    s.want  = want;
    return s;
  endfunction

  // Mirror a register write into the shadow copy; unknown indexes are dropped.
  function automatic void apply_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    case (addr[PADDR_W-1:2])
      REG_START_INDEX: begin
        cfg_start     = data[START_W-1:0];
        anim_sprite   = SPRITE_W'(data[START_W-1:0]);
        anim_position = '0;
        anim_elapsed  = '0;
      end
      REG_FRAME_COUNT:     cfg_frames  = data[FRAMES_W-1:0];
      REG_FRAME_TICKS:     cfg_fticks  = data[FTICKS_W-1:0];
      REG_SPRITE_WIDTH:    cfg_width   = data[SIZE_W-1:0];
      REG_SPRITE_HEIGHT:   cfg_height  = data[SIZE_W-1:0];
      REG_SPRITES_PER_ROW: cfg_per_row = data[PER_ROW_W-1:0];
      REG_MIRROR:          cfg_mirror  = data[0];
      default: ;
    endcase
  endfunction

  // Advance the animation timer by one tick transaction and return the source rectangle.
  function automatic rect_t advance_animation(logic [TICKS_W-1:0] t);
    int unsigned frames;
    int unsigned per_row;
    int unsigned sum;
    int unsigned pos;
    int unsigned col;
    int unsigned row;
    int unsigned left;
    int unsigned w;
    rect_t       r;
    // Clamp the frame count and the row length into their usable ranges.
    frames  = cfg_frames;
    if (frames == 0) frames = 1;
    if (frames > MAX_FRAMES) frames = MAX_FRAMES;
    per_row = cfg_per_row;
    if (per_row == 0) per_row = 1;
    if (per_row > MAX_PER_ROW) per_row = MAX_PER_ROW;
    // Saturate the timer, then advance when it strictly exceeds the frame duration.
    sum = anim_elapsed + t;
    if (sum > ELAPSED_MAX) sum = ELAPSED_MAX;
    anim_elapsed = ELAPSED_W'(sum);
    if (anim_elapsed > cfg_fticks) begin
      pos           = (int'(anim_position) + 1) % frames;
      anim_position = POS_W'(pos);
      anim_sprite   = SPRITE_W'(cfg_start + pos);
      anim_elapsed  = '0;
    end
    col  = anim_sprite % per_row;
    row  = anim_sprite / per_row;
    left = col * cfg_width;
    w    = cfg_width;
    if (cfg_mirror) begin
      left += cfg_width;
      w     = 0 - int'(cfg_width);
    end
    r.left   = LEFT_W'(left);
    r.top    = TOP_W'(row * cfg_height);
    r.width  = RWIDTH_W'(w);
    r.height = cfg_height;
    r.sprite = anim_sprite;
    return r;
  endfunction

  // Write one register: setup cycle, access cycle, then release the bus.
  task automatic program_reg(logic [2:0] idx, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_addr(idx);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_write(reg_addr(idx), data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid, wait for every outstanding rectangle, then let the pipeline drain.
  task automatic settle();
    if (unsettled) begin
      ticks_valid <= 1'b0;
      while (rects_due.size() != 0) @(negedge clk);
      repeat (SETTLE_CYCLES) @(negedge clk);
      unsettled = 1'b0;
    end
  endtask

  // Offer one tick transaction; valid stays high on return so back-to-back items need no gap.
  task automatic send_ticks(logic [TICKS_W-1:0] t, bit fixed, rect_t want);
    rect_t due;
    while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
      ticks_valid <= 1'b0;
      @(negedge clk);
    end
    ticks_valid <= 1'b1;
    ticks       <= t;
    @(posedge clk);
    while (!ticks_ready) @(posedge clk);
    due = advance_animation(t);
    rects_due.push_back(fixed ? want : due);
    ticks_sent++;
    calm      = (ticks_sent >= CALM_FIRST) && (ticks_sent < CALM_LAST);
    unsettled = 1'b1;
    @(negedge clk);
  endtask

  // Compare every accepted rectangle with the oldest one still due.
  always @(posedge clk) begin
    rect_t due;
    if (!rst && rect_valid && rect_ready) begin
      if (rects_due.size() == 0) begin
        $error("rectangle with none due: current_sprite %0d", current_sprite);
        errors++;
      end else begin
        due = rects_due.pop_front();
        if (rect_left !== due.left) begin
          $error("rect_left: expected %0d, got %0d", due.left, rect_left);
          errors++;
        end
        if (rect_top !== due.top) begin
          $error("rect_top: expected %0d, got %0d", due.top, rect_top);
          errors++;
        end
        if (rect_width !== due.width) begin
          $error("rect_width: expected %0d, got %0d", due.width, rect_width);
          errors++;
        end
        if (rect_height !== due.height) begin
          $error("rect_height: expected %0d, got %0d", due.height, rect_height);
          errors++;
        end
        if (current_sprite !== due.sprite) begin
          $error("current_sprite: expected %0d, got %0d", due.sprite, current_sprite);
          errors++;
        end
      end
    end
  end

  initial begin
    step_t              plan[$];
    logic [2:0]         idx;
    logic [PDATA_W-1:0] noise;
    logic [PDATA_W-1:0] mask;
    int unsigned        v;
    int unsigned        roll;
    int unsigned        fw;
    int unsigned        burst;
    int unsigned        random_sent;
    bit                 pick;

    // Reset defaults: one frame, zero duration, unit sprite; the frame never moves.
    plan.push_back(fixed_row(8'd0,   rect_of(0, 0, 1, 1, 0)));
    plan.push_back(fixed_row(8'd255, rect_of(0, 0, 1, 1, 0)));
    // Every register at its top value; the timer cannot pass the longest duration.
    plan.push_back(write_row(REG_START_INDEX,     32'd4095));
    plan.push_back(write_row(REG_FRAME_COUNT,     32'd4096));
    plan.push_back(write_row(REG_FRAME_TICKS,     32'h00FF_FFFF));
    plan.push_back(write_row(REG_SPRITE_WIDTH,    32'd4095));
    plan.push_back(write_row(REG_SPRITE_HEIGHT,   32'd4095));
    plan.push_back(write_row(REG_SPRITES_PER_ROW, 32'd256));
    plan.push_back(write_row(REG_MIRROR,          32'd1));
    plan.push_back(fixed_row(8'd255, rect_of(1048320, 61425, -4095, 4095, 4095)));
    // Zero-sized sprite; mirror cleared through a write with noisy upper bits.
    plan.push_back(write_row(REG_FRAME_TICKS,     32'd0));
    plan.push_back(write_row(REG_MIRROR,          32'hFFFF_FFFE));
    plan.push_back(write_row(REG_SPRITE_WIDTH,    32'd0));
    plan.push_back(write_row(REG_SPRITE_HEIGHT,   32'd0));
    plan.push_back(tick_row(8'd1));
    plan.push_back(tick_row(8'd200));
    // Three-frame loop: hold at exactly the duration, advance one past it, then wrap.
    plan.push_back(write_row(REG_START_INDEX,     32'hFFFF_F005));
    plan.push_back(write_row(REG_FRAME_COUNT,     32'd3));
    plan.push_back(write_row(REG_FRAME_TICKS,     32'd10));
    plan.push_back(write_row(REG_SPRITE_WIDTH,    32'd16));
    plan.push_back(write_row(REG_SPRITE_HEIGHT,   32'd8));
    plan.push_back(write_row(REG_SPRITES_PER_ROW, 32'd4));
    plan.push_back(tick_row(8'd10));
    plan.push_back(tick_row(8'd1));
    plan.push_back(tick_row(8'd11));
    plan.push_back(tick_row(8'd128));
    // Zero frames behaves as one.
    plan.push_back(write_row(REG_FRAME_COUNT,     32'd0));
    plan.push_back(tick_row(8'd64));
    // Oversized frame count clamps to the maximum; walk the position forward.
    plan.push_back(write_row(REG_FRAME_COUNT,     32'd5000));
    plan.push_back(write_row(REG_FRAME_TICKS,     32'd0));
    plan.push_back(tick_row(8'd3));
    plan.push_back(tick_row(8'd3));
    plan.push_back(tick_row(8'd3));
    // Shrink the loop below the current position; the next advance still wraps.
    plan.push_back(write_row(REG_FRAME_COUNT,     32'd2));
    plan.push_back(tick_row(8'd7));
    // Zero and oversized row lengths.
    plan.push_back(write_row(REG_SPRITES_PER_ROW, 32'd0));
    plan.push_back(write_row(REG_MIRROR,          32'd1));
    plan.push_back(tick_row(8'd0));
    plan.push_back(write_row(REG_SPRITES_PER_ROW, 32'd511));
    plan.push_back(tick_row(8'd9));
    // A write to the unused slot must leave everything alone.
    plan.push_back(write_row(REG_UNUSED,          32'hFFFF_FFFF));
    plan.push_back(tick_row(8'd0));

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        program_reg(plan[i].reg_idx, plan[i].data);
      end else begin
        send_ticks(plan[i].tick_count, plan[i].fixed, plan[i].want);
      end
    end

    // Random phases: reprogram a random subset of registers while idle, then run a burst.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      settle();
      for (int r = 0; r <= int'(REG_UNUSED); r++) begin
        idx   = 3'(r);
        noise = ($urandom_range(3) == 0) ? PDATA_W'($urandom()) : '0;
        roll  = $urandom_range(9);
        pick  = ($urandom_range(1) == 0);
        case (idx)
          REG_START_INDEX: begin
            // Reload the animation less often so positions can grow.
            pick = ($urandom_range(3) == 0);
            fw   = START_W;
            v    = (roll == 0) ? 0 : (roll == 1) ? 4095 : $urandom_range(4095);
          end
          REG_FRAME_COUNT: begin
            fw = FRAMES_W;
            v  = (roll == 0) ? 0 : (roll == 1) ? 1 : (roll == 2) ? 4096 :
                 (roll == 3) ? $urandom_range(8191, 4097) :
                 (roll < 7)  ? $urandom_range(8, 2) : $urandom_range(4096, 2);
          end
          REG_FRAME_TICKS: begin
            fw = FTICKS_W;
            v  = (roll == 0) ? 0 : (roll == 1) ? 24'hFF_FFFF :
                 (roll == 2) ? $urandom_range(24'hFF_FFFF) :
                 (roll < 6)  ? $urandom_range(3000) : $urandom_range(400);
          end
          REG_SPRITE_WIDTH, REG_SPRITE_HEIGHT: begin
            fw = SIZE_W;
            v  = (roll == 0) ? 0 : (roll == 1) ? 4095 :
                 (roll < 6)  ? $urandom_range(64, 1) : $urandom_range(4095);
          end
          REG_SPRITES_PER_ROW: begin
            fw = PER_ROW_W;
            v  = (roll == 0) ? 0 : (roll == 1) ? 1 : (roll == 2) ? 256 :
                 (roll == 3) ? $urandom_range(511, 257) :
                 (roll < 7)  ? $urandom_range(16, 2) : $urandom_range(256, 1);
          end
          REG_MIRROR: begin
            fw = 1;
            v  = $urandom_range(1);
          end
          default: begin
            // Unused slot: any pattern, seldom.
            pick = ($urandom_range(7) == 0);
            fw   = PDATA_W;
            v    = $urandom();
          end
        endcase
        // Keep the field bits, fill the rest with noise.
        mask  = (PDATA_W'(1) << fw) - 1;
        if (pick) program_reg(idx, (noise & ~mask) | (PDATA_W'(v) & mask));
      end
      burst = $urandom_range(60, 8);
      repeat (burst) begin
        roll = $urandom_range(7);
        send_ticks((roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : TICKS_W'($urandom_range(255)),
                   1'b0, '0);
        random_sent++;
      end
    end

    // Drain what is still in flight before judging the run.
    settle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
